// ----- rtl/core/three_level_exclusive_cache_policy_macros.svh -----
// assertion macros for the three-level exclusive cache policy
// used by the top level only, no other dependencies
`ifndef THREE_LEVEL_EXCLUSIVE_CACHE_POLICY_MACROS_SVH
`define THREE_LEVEL_EXCLUSIVE_CACHE_POLICY_MACROS_SVH

// property must hold on every clock edge outside reset
`define TLEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TLEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/tlec_pkg.sv -----
// types and constants for the three-level exclusive cache policy
// no dependencies
package tlec_pkg;

  localparam int unsigned CostW  = 20;
  localparam int unsigned TotalW = 40;
  localparam int unsigned CntW   = 32;
  localparam int unsigned AddrW  = 10;

  localparam logic [CostW-1:0] L1CostRst  = 20'd10;
  localparam logic [CostW-1:0] L2CostRst  = 20'd110;
  localparam logic [CostW-1:0] L3CostRst  = 20'd1110;
  localparam logic [CostW-1:0] MemCostRst = 20'd101110;

  localparam logic [1:0] RegL1Cost  = 2'd0;
  localparam logic [1:0] RegL2Cost  = 2'd1;
  localparam logic [1:0] RegL3Cost  = 2'd2;
  localparam logic [1:0] RegMemCost = 2'd3;

  localparam logic OpAccess  = 1'b0;
  localparam logic OpMarkUse = 1'b1;

  localparam logic [1:0] LvlL1   = 2'd0;
  localparam logic [1:0] LvlL2   = 2'd1;
  localparam logic [1:0] LvlL3   = 2'd2;
  localparam logic [1:0] LvlMiss = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StMark,
    StScan1,
    StScan2,
    StScan3,
    StProm2,
    StSwap2,
    StProm3a,
    StSwap3a,
    StProm3b,
    StSwap3b,
    StVict,
    StFill,
    StDone,
    StOut
  } state_e;

  function automatic logic [CntW-1:0] sat_inc32(input logic [CntW-1:0] v);
    sat_inc32 = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/core/three_level_exclusive_cache_policy.sv -----
// Three-level exclusive cache policy (tags and use counts only). An access
// word walks L1, L2, L3 one entry per cycle with a single shared tag/count
// comparator; a miss searches every L1, L2 and L3 entry and then scans them
// all again for the least-count victims. Promotions scan the level above once
// per step and swap with the first entry whose count is not above the promoted
// one. The result of an access appears on the output register and is held
// until taken; the next word is accepted only after that. No clearing pass:
// valid bits and counts reset at once. Depends on tlec_pkg, tlec_level and the
// macros header.
module three_level_exclusive_cache_policy #(
  parameter int unsigned L1_ENTRIES    = 8,
  parameter int unsigned L2_ENTRIES    = 16,
  parameter int unsigned L3_ENTRIES    = 32,
  parameter int unsigned MEMORY_BLOCKS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tlec_pkg::CostW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [tlec_pkg::AddrW-1:0]    block_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    hit_level_o,
  output logic [tlec_pkg::CostW-1:0]    access_cost_o,
  output logic [tlec_pkg::TotalW-1:0]   total_cost_o,
  output logic [tlec_pkg::CntW-1:0]     l1_hit_count_o,
  output logic [tlec_pkg::CntW-1:0]     l1_miss_count_o,
  output logic [tlec_pkg::CntW-1:0]     l2_hit_count_o,
  output logic [tlec_pkg::CntW-1:0]     l2_miss_count_o,
  output logic [tlec_pkg::CntW-1:0]     l3_hit_count_o,
  output logic [tlec_pkg::CntW-1:0]     l3_miss_count_o
);
  import tlec_pkg::*;
  `include "three_level_exclusive_cache_policy_macros.svh"

  localparam int unsigned I1W = (L1_ENTRIES > 1) ? $clog2(L1_ENTRIES) : 1;
  localparam int unsigned I2W = (L2_ENTRIES > 1) ? $clog2(L2_ENTRIES) : 1;
  localparam int unsigned I3W = (L3_ENTRIES > 1) ? $clog2(L3_ENTRIES) : 1;
  localparam int unsigned IW  = (I3W > I2W) ? ((I3W > I1W) ? I3W : I1W)
                                            : ((I2W > I1W) ? I2W : I1W);
  localparam int unsigned BW  = $clog2(MEMORY_BLOCKS);
  localparam logic [IW-1:0] L1Last = IW'(L1_ENTRIES - 1);
  localparam logic [IW-1:0] L2Last = IW'(L2_ENTRIES - 1);
  localparam logic [IW-1:0] L3Last = IW'(L3_ENTRIES - 1);
  // address wrap by reciprocal multiply, exact for every 10-bit address
  localparam int unsigned ModSh  = AddrW + BW;
  localparam int unsigned ModRW  = AddrW + 2;
  localparam logic [ModRW-1:0] ModRecip =
    ModRW'(((64'd1 << ModSh) + 64'(MEMORY_BLOCKS) - 64'd1) / 64'(MEMORY_BLOCKS));

  // configuration
  logic [CostW-1:0] l1_cost_q, l2_cost_q, l3_cost_q, mem_cost_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_cost_q  <= L1CostRst;
      l2_cost_q  <= L2CostRst;
      l3_cost_q  <= L3CostRst;
      mem_cost_q <= MemCostRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegL1Cost:  l1_cost_q  <= cfg_data_i;
        RegL2Cost:  l2_cost_q  <= cfg_data_i;
        RegL3Cost:  l3_cost_q  <= cfg_data_i;
        RegMemCost: mem_cost_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // block number modulo the memory size
  logic [AddrW+ModRW-1:0] mod_prod;
  logic [AddrW-1:0]       mod_quo, mod_rem;
  assign mod_prod = block_address_i * ModRecip;
  assign mod_quo  = AddrW'(mod_prod >> ModSh);
  assign mod_rem  = block_address_i - AddrW'(mod_quo * MEMORY_BLOCKS);

  // sequencer state
  state_e           state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;        // scan pointer
  logic [IW-1:0]    hit_q, hit_d;        // hit entry / victim slot (lower level)
  logic [IW-1:0]    v2_q, v2_d;          // l2 victim for fill / l2 slot in 3-level promote
  logic [IW-1:0]    v3_q, v3_d;          // l3 victim for fill
  logic [CntW-1:0]  best_q, best_d;      // running minimum / promoted count
  logic [1:0]       lvl_q, lvl_d;        // level being scanned for victim
  logic [BW-1:0]    addr_q, addr_d;
  logic [1:0]       last_lvl_q, last_lvl_d;
  logic [IW-1:0]    last_idx_q, last_idx_d;
  logic [1:0]       res_lvl_q, res_lvl_d;
  // swap holding register
  logic             hv_q, hv_d;
  logic [BW-1:0]    ht_q, ht_d;
  logic [CntW-1:0]  hc_q, hc_d;

  // level stores
  logic [I1W-1:0] r1_idx, w1_idx;
  logic [I2W-1:0] r2_idx, w2_idx;
  logic [I3W-1:0] r3_idx, w3_idx;
  logic r1_v, r2_v, r3_v, w1_en, w2_en, w3_en, w1_v, w2_v, w3_v;
  logic [BW-1:0] r1_t, r2_t, r3_t, w1_t, w2_t, w3_t;
  logic [CntW-1:0] r1_c, r2_c, r3_c, w1_c, w2_c, w3_c;

  tlec_level #(.Entries(L1_ENTRIES), .IdxW(I1W), .TagW(BW)) u_l1 (
    .clk_i, .rst_ni, .rd_idx_i(r1_idx), .rd_vld_o(r1_v), .rd_tag_o(r1_t),
    .rd_cnt_o(r1_c), .wr_en_i(w1_en), .wr_idx_i(w1_idx), .wr_vld_i(w1_v),
    .wr_tag_i(w1_t), .wr_cnt_i(w1_c));
  tlec_level #(.Entries(L2_ENTRIES), .IdxW(I2W), .TagW(BW)) u_l2 (
    .clk_i, .rst_ni, .rd_idx_i(r2_idx), .rd_vld_o(r2_v), .rd_tag_o(r2_t),
    .rd_cnt_o(r2_c), .wr_en_i(w2_en), .wr_idx_i(w2_idx), .wr_vld_i(w2_v),
    .wr_tag_i(w2_t), .wr_cnt_i(w2_c));
  tlec_level #(.Entries(L3_ENTRIES), .IdxW(I3W), .TagW(BW)) u_l3 (
    .clk_i, .rst_ni, .rd_idx_i(r3_idx), .rd_vld_o(r3_v), .rd_tag_o(r3_t),
    .rd_cnt_o(r3_c), .wr_en_i(w3_en), .wr_idx_i(w3_idx), .wr_vld_i(w3_v),
    .wr_tag_i(w3_t), .wr_cnt_i(w3_c));

  // shared compare unit: tag match and count compare on the selected level
  logic            sel_v;
  logic [BW-1:0]   sel_t;
  logic [CntW-1:0] sel_c;
  logic            tag_eq, cnt_lt, cnt_le;
  logic [1:0]      sel_lvl;
  always_comb begin
    case (sel_lvl)
      LvlL1:   begin sel_v = r1_v; sel_t = r1_t; sel_c = r1_c; end
      LvlL2:   begin sel_v = r2_v; sel_t = r2_t; sel_c = r2_c; end
      default: begin sel_v = r3_v; sel_t = r3_t; sel_c = r3_c; end
    endcase
  end
  assign tag_eq = sel_v && (sel_t == addr_q);
  assign cnt_lt = sel_c < best_q;
  assign cnt_le = sel_c <= best_q;

  // output register and statistics
  logic              out_valid_q;
  logic [1:0]        hit_level_q;
  logic [CostW-1:0]  cost_q;
  logic [TotalW-1:0] total_q;
  logic [CntW-1:0]   hm_q [6];
  logic              fin;
  logic [CostW-1:0]  fin_cost;
  logic [TotalW:0]   sum;

  logic in_acc;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    case (res_lvl_q)
      LvlL1:   fin_cost = l1_cost_q;
      LvlL2:   fin_cost = l2_cost_q;
      LvlL3:   fin_cost = l3_cost_q;
      default: fin_cost = mem_cost_q;
    endcase
  end
  assign sum = {1'b0, total_q} + {{(TotalW+1-CostW){1'b0}}, fin_cost};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_acc) state_d = (op_i == OpMarkUse) ? StMark : StScan1;
      StMark:   state_d = StIdle;
      StScan1:  if (tag_eq) state_d = StDone;
                else if (idx_q == L1Last) state_d = StScan2;
      StScan2:  if (tag_eq) state_d = StProm2;
                else if (idx_q == L2Last) state_d = StScan3;
      StScan3:  if (tag_eq) state_d = StProm3a;
                else if (idx_q == L3Last) state_d = StVict;
      StProm2:  if (cnt_le) state_d = StSwap2;
                else if (idx_q == L1Last) state_d = StDone;
      StSwap2:  state_d = StDone;
      StProm3a: if (cnt_le) state_d = StSwap3a;
                else if (idx_q == L2Last) state_d = StDone;
      StSwap3a: state_d = StProm3b;
      StProm3b: if (cnt_le) state_d = StSwap3b;
                else if (idx_q == L1Last) state_d = StDone;
      StSwap3b: state_d = StDone;
      StVict:   if (lvl_q == LvlL1 && idx_q == L1Last) state_d = StFill;
      StFill:   state_d = StDone;
      StDone:   state_d = StOut;
      StOut:    if (!out_stall_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // datapath and store control
  always_comb begin
    idx_d = idx_q; hit_d = hit_q; v2_d = v2_q; v3_d = v3_q; best_d = best_q;
    lvl_d = lvl_q; addr_d = addr_q; last_lvl_d = last_lvl_q; last_idx_d = last_idx_q;
    res_lvl_d = res_lvl_q; hv_d = hv_q; ht_d = ht_q; hc_d = hc_q;
    sel_lvl = LvlL1;
    r1_idx = I1W'(idx_q); r2_idx = I2W'(idx_q); r3_idx = I3W'(idx_q);
    w1_en = 1'b0; w2_en = 1'b0; w3_en = 1'b0;
    w1_idx = I1W'(idx_q); w2_idx = I2W'(idx_q); w3_idx = I3W'(idx_q);
    w1_v = r1_v; w2_v = r2_v; w3_v = r3_v;
    w1_t = r1_t; w2_t = r2_t; w3_t = r3_t;
    w1_c = r1_c; w2_c = r2_c; w3_c = r3_c;
    fin = 1'b0;
    case (state_q)
      StIdle: begin
        idx_d  = '0;
        addr_d = BW'(mod_rem);
      end
      StMark: begin
        r1_idx = I1W'(last_idx_q); r2_idx = I2W'(last_idx_q);
        r3_idx = I3W'(last_idx_q);
        w1_idx = r1_idx; w2_idx = r2_idx; w3_idx = r3_idx;
        w1_c = sat_inc32(r1_c); w2_c = sat_inc32(r2_c); w3_c = sat_inc32(r3_c);
        w1_en = (last_lvl_q == LvlL1);
        w2_en = (last_lvl_q == LvlL2);
        w3_en = (last_lvl_q == LvlL3);
      end
      StScan1: begin
        sel_lvl = LvlL1;
        if (tag_eq) begin
          res_lvl_d = LvlL1; last_lvl_d = LvlL1; last_idx_d = idx_q;
        end else idx_d = (idx_q == L1Last) ? '0 : idx_q + 1'b1;
      end
      StScan2: begin
        sel_lvl = LvlL2;
        if (tag_eq) begin
          res_lvl_d = LvlL2; hit_d = idx_q; best_d = r2_c; idx_d = '0;
          last_lvl_d = LvlL2; last_idx_d = idx_q;
        end else idx_d = (idx_q == L2Last) ? '0 : idx_q + 1'b1;
      end
      StScan3: begin
        sel_lvl = LvlL3;
        if (tag_eq) begin
          res_lvl_d = LvlL3; hit_d = idx_q; best_d = r3_c; idx_d = '0;
          last_lvl_d = LvlL3; last_idx_d = idx_q;
        end else if (idx_q == L3Last) begin
          // start least-count search at l3
          res_lvl_d = LvlMiss; lvl_d = LvlL3; idx_d = '0;
          best_d = '1; v3_d = '0; v2_d = '0; hit_d = '0;
        end else idx_d = idx_q + 1'b1;
      end
      StProm2: begin
        sel_lvl = LvlL1;
        if (cnt_le) begin
          // latch upper entry, write lower entry into it
          hv_d = r1_v; ht_d = r1_t; hc_d = r1_c;
          r2_idx = I2W'(hit_q);
          w1_en = 1'b1; w1_v = r2_v; w1_t = r2_t; w1_c = r2_c;
          last_lvl_d = LvlL1; last_idx_d = idx_q;
        end else idx_d = idx_q + 1'b1;
      end
      StSwap2: begin
        w2_en = 1'b1; w2_idx = I2W'(hit_q); w2_v = hv_q; w2_t = ht_q; w2_c = hc_q;
      end
      StProm3a: begin
        sel_lvl = LvlL2;
        if (cnt_le) begin
          hv_d = r2_v; ht_d = r2_t; hc_d = r2_c;
          r3_idx = I3W'(hit_q);
          w2_en = 1'b1; w2_v = r3_v; w2_t = r3_t; w2_c = r3_c;
          last_lvl_d = LvlL2; last_idx_d = idx_q; v2_d = idx_q;
        end else idx_d = idx_q + 1'b1;
      end
      StSwap3a: begin
        w3_en = 1'b1; w3_idx = I3W'(hit_q); w3_v = hv_q; w3_t = ht_q; w3_c = hc_q;
        idx_d = '0;
      end
      StProm3b: begin
        sel_lvl = LvlL1;
        if (cnt_le) begin
          hv_d = r1_v; ht_d = r1_t; hc_d = r1_c;
          r2_idx = I2W'(v2_q);
          w1_en = 1'b1; w1_v = r2_v; w1_t = r2_t; w1_c = r2_c;
          last_lvl_d = LvlL1; last_idx_d = idx_q;
        end else idx_d = idx_q + 1'b1;
      end
      StSwap3b: begin
        w2_en = 1'b1; w2_idx = I2W'(v2_q); w2_v = hv_q; w2_t = ht_q; w2_c = hc_q;
      end
      StVict: begin
        // least count per level, lowest index on ties
        sel_lvl = lvl_q;
        if (idx_q == '0 || cnt_lt) begin
          best_d = sel_c;
          case (lvl_q)
            LvlL3:   v3_d = idx_q;
            LvlL2:   v2_d = idx_q;
            default: hit_d = idx_q;
          endcase
        end
        if ((lvl_q == LvlL3 && idx_q == L3Last) || (lvl_q == LvlL2 && idx_q == L2Last))
        begin
          lvl_d = lvl_q - 1'b1; idx_d = '0;
        end else if (!(lvl_q == LvlL1 && idx_q == L1Last)) idx_d = idx_q + 1'b1;
      end
      StFill: begin
        // cascade: l2 victim to l3, l1 victim to l2, new block to l1
        r1_idx = I1W'(hit_q); r2_idx = I2W'(v2_q);
        w3_en = 1'b1; w3_idx = I3W'(v3_q); w3_v = r2_v; w3_t = r2_t; w3_c = r2_c;
        w2_en = 1'b1; w2_idx = I2W'(v2_q); w2_v = r1_v; w2_t = r1_t; w2_c = r1_c;
        w1_en = 1'b1; w1_idx = I1W'(hit_q); w1_v = 1'b1; w1_t = addr_q; w1_c = '0;
        last_lvl_d = LvlL1; last_idx_d = hit_q;
      end
      StDone: fin = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; last_lvl_q <= LvlL1; last_idx_q <= '0;
      out_valid_q <= 1'b0; total_q <= '0;
      for (int i = 0; i < 6; i++) hm_q[i] <= '0;
    end else begin
      state_q <= state_d; last_lvl_q <= last_lvl_d; last_idx_q <= last_idx_d;
      if (fin) begin
        out_valid_q <= 1'b1;
        total_q <= sum[TotalW] ? '1 : sum[TotalW-1:0];
        case (res_lvl_q)
          LvlL1: hm_q[0] <= sat_inc32(hm_q[0]);
          LvlL2: begin
            hm_q[1] <= sat_inc32(hm_q[1]); hm_q[2] <= sat_inc32(hm_q[2]);
          end
          LvlL3: begin
            hm_q[1] <= sat_inc32(hm_q[1]); hm_q[3] <= sat_inc32(hm_q[3]);
            hm_q[4] <= sat_inc32(hm_q[4]);
          end
          default: begin
            hm_q[1] <= sat_inc32(hm_q[1]); hm_q[3] <= sat_inc32(hm_q[3]);
            hm_q[5] <= sat_inc32(hm_q[5]);
          end
        endcase
      end else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; hit_q <= hit_d; v2_q <= v2_d; v3_q <= v3_d; best_q <= best_d;
    lvl_q <= lvl_d; addr_q <= addr_d; res_lvl_q <= res_lvl_d;
    hv_q <= hv_d; ht_q <= ht_d; hc_q <= hc_d;
    if (fin) begin
      hit_level_q <= res_lvl_q;
      cost_q      <= fin_cost;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_level_o     = hit_level_q;
  assign access_cost_o   = cost_q;
  assign total_cost_o    = total_q;
  assign l1_hit_count_o  = hm_q[0];
  assign l1_miss_count_o = hm_q[1];
  assign l2_hit_count_o  = hm_q[2];
  assign l2_miss_count_o = hm_q[3];
  assign l3_hit_count_o  = hm_q[4];
  assign l3_miss_count_o = hm_q[5];

  // output word is valid exactly while waiting in the hand-off state
  `TLEC_ASSERT(a_out_state, out_valid_q == (state_q == StOut), "out valid without result state")
  // a result is only built from a scan, never straight from idle
  `TLEC_ASSERT_NEXT(a_idle_no_out, state_q == StIdle, !out_valid_q, "result out of idle")
  // l1 misses never fall behind l2 hits, unless the l1 miss count has saturated
  `TLEC_ASSERT(a_cnt_order, hm_q[1] >= hm_q[2] || hm_q[1] == '1, "miss counts inconsistent")
endmodule

// ----- rtl/core/tlec_level.sv -----
// one cache level: tag store with valid bits and use-count store
// depends on tlec_pkg
module tlec_level #(
  parameter int unsigned Entries = 8,
  parameter int unsigned IdxW    = 3,
  parameter int unsigned TagW    = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [IdxW-1:0]              rd_idx_i,
  output logic                         rd_vld_o,
  output logic [TagW-1:0]              rd_tag_o,
  output logic [tlec_pkg::CntW-1:0]    rd_cnt_o,
  input  logic                         wr_en_i,
  input  logic [IdxW-1:0]              wr_idx_i,
  input  logic                         wr_vld_i,
  input  logic [TagW-1:0]              wr_tag_i,
  input  logic [tlec_pkg::CntW-1:0]    wr_cnt_i
);
  import tlec_pkg::*;

  logic [Entries-1:0]  vld_q;
  logic [TagW-1:0]     tag_q [Entries];
  logic [CntW-1:0]     cnt_q [Entries];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      for (int i = 0; i < Entries; i++) cnt_q[i] <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_idx_i] <= wr_vld_i;
      cnt_q[wr_idx_i] <= wr_cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) tag_q[wr_idx_i] <= wr_tag_i;
  end

  assign rd_vld_o = vld_q[rd_idx_i];
  assign rd_tag_o = tag_q[rd_idx_i];
  assign rd_cnt_o = cnt_q[rd_idx_i];
endmodule
